// File: hdl/playfair_digraph_encryptor_unit_defines.svh
// Assertion macros for the Playfair encryptor checker.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define PFE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define PFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pfe_pkg.sv
// Package: constants, microcode table and square index helpers for the Playfair encryptor.
package pfe_pkg;

   localparam int LETTERS  = 26;
   localparam int CELLS    = 25;
   localparam int LETTER_W = 5;

   localparam logic [4:0] LETTER_J    = 5'd9;
   localparam logic [4:0] LETTER_Q    = 5'd16;
   localparam logic [4:0] LETTER_X    = 5'd23;
   localparam logic [4:0] LETTER_LAST = 5'd25;

   localparam logic [1:0] REQ_KEY = 2'd0;
   localparam logic [1:0] REQ_MSG = 2'd1;
   localparam logic [1:0] REQ_END = 2'd2;

   // datapath actions
   localparam logic [3:0] ACT_NONE      = 4'd0;
   localparam logic [3:0] ACT_PLACE_IN  = 4'd1;
   localparam logic [3:0] ACT_WALK_CLR  = 4'd2;
   localparam logic [3:0] ACT_WALK      = 4'd3;
   localparam logic [3:0] ACT_CLOSE     = 4'd4;
   localparam logic [3:0] ACT_SET_B     = 4'd5;
   localparam logic [3:0] ACT_RD_PB     = 4'd6;
   localparam logic [3:0] ACT_CAP_PB    = 4'd7;
   localparam logic [3:0] ACT_RD_Q2     = 4'd8;
   localparam logic [3:0] ACT_CAP_Q2    = 4'd9;
   localparam logic [3:0] ACT_EMIT      = 4'd10;
   localparam logic [3:0] ACT_PAIR_DONE = 4'd11;
   localparam logic [3:0] ACT_HOLD      = 4'd12;
   localparam logic [3:0] ACT_SET_PAD   = 4'd13;
   localparam logic [3:0] ACT_CLEAR     = 4'd14;

   // jump conditions
   localparam logic [3:0] COND_NEVER      = 4'd0;
   localparam logic [3:0] COND_ALWAYS     = 4'd1;
   localparam logic [3:0] COND_NO_WORD    = 4'd2;
   localparam logic [3:0] COND_IS_KEY     = 4'd3;
   localparam logic [3:0] COND_IS_MSG     = 4'd4;
   localparam logic [3:0] COND_IS_END     = 4'd5;
   localparam logic [3:0] COND_BAD_LETTER = 4'd6;
   localparam logic [3:0] COND_CLOSED     = 4'd7;
   localparam logic [3:0] COND_WALK_MORE  = 4'd8;
   localparam logic [3:0] COND_IS_J       = 4'd9;
   localparam logic [3:0] COND_NO_HELD    = 4'd10;
   localparam logic [3:0] COND_OUT_BUSY   = 4'd11;

   // program steps
   localparam logic [4:0] S_FETCH     = 5'd0;
   localparam logic [4:0] S_DEC_KEY   = 5'd1;
   localparam logic [4:0] S_DEC_MSG   = 5'd2;
   localparam logic [4:0] S_DEC_END   = 5'd3;
   localparam logic [4:0] S_DEC_OTHER = 5'd4;
   localparam logic [4:0] S_KEY       = 5'd5;
   localparam logic [4:0] S_MSG       = 5'd6;
   localparam logic [4:0] S_MSG_CLOSE = 5'd7;
   localparam logic [4:0] S_WALK      = 5'd8;
   localparam logic [4:0] S_CLOSE     = 5'd9;
   localparam logic [4:0] S_CHECK_J   = 5'd10;
   localparam logic [4:0] S_CHECK_H   = 5'd11;
   localparam logic [4:0] S_SET_B     = 5'd12;
   localparam logic [4:0] S_ENC       = 5'd13;
   localparam logic [4:0] S_RD_PB     = 5'd14;
   localparam logic [4:0] S_CAP_PB    = 5'd15;
   localparam logic [4:0] S_RD_Q1     = 5'd16;
   localparam logic [4:0] S_RD_Q2     = 5'd17;
   localparam logic [4:0] S_CAP_Q2    = 5'd18;
   localparam logic [4:0] S_WAIT      = 5'd19;
   localparam logic [4:0] S_EMIT      = 5'd20;
   localparam logic [4:0] S_PAIR_DONE = 5'd21;
   localparam logic [4:0] S_HOLD      = 5'd22;
   localparam logic [4:0] S_END       = 5'd23;
   localparam logic [4:0] S_PAD       = 5'd24;
   localparam logic [4:0] S_CLEAR     = 5'd25;

   typedef struct packed {
      logic [3:0] act;
      logic [3:0] cond;
      logic [4:0] target;
   } uword_type;

   function automatic uword_type ucode(input logic [4:0] pc);
      uword_type w;
      unique case (pc)
         S_FETCH:     w = '{act: ACT_NONE,      cond: COND_NO_WORD,    target: S_FETCH};
         S_DEC_KEY:   w = '{act: ACT_NONE,      cond: COND_IS_KEY,     target: S_KEY};
         S_DEC_MSG:   w = '{act: ACT_NONE,      cond: COND_IS_MSG,     target: S_MSG};
         S_DEC_END:   w = '{act: ACT_NONE,      cond: COND_IS_END,     target: S_END};
         S_DEC_OTHER: w = '{act: ACT_NONE,      cond: COND_ALWAYS,     target: S_FETCH};
         S_KEY:       w = '{act: ACT_PLACE_IN,  cond: COND_ALWAYS,     target: S_FETCH};
         S_MSG:       w = '{act: ACT_NONE,      cond: COND_BAD_LETTER, target: S_FETCH};
         S_MSG_CLOSE: w = '{act: ACT_WALK_CLR,  cond: COND_CLOSED,     target: S_CHECK_J};
         S_WALK:      w = '{act: ACT_WALK,      cond: COND_WALK_MORE,  target: S_WALK};
         S_CLOSE:     w = '{act: ACT_CLOSE,     cond: COND_NEVER,      target: S_FETCH};
         S_CHECK_J:   w = '{act: ACT_NONE,      cond: COND_IS_J,       target: S_FETCH};
         S_CHECK_H:   w = '{act: ACT_NONE,      cond: COND_NO_HELD,    target: S_HOLD};
         S_SET_B:     w = '{act: ACT_SET_B,     cond: COND_NEVER,      target: S_FETCH};
         S_ENC:       w = '{act: ACT_NONE,      cond: COND_NEVER,      target: S_FETCH};
         S_RD_PB:     w = '{act: ACT_RD_PB,     cond: COND_NEVER,      target: S_FETCH};
         S_CAP_PB:    w = '{act: ACT_CAP_PB,    cond: COND_NEVER,      target: S_FETCH};
         S_RD_Q1:     w = '{act: ACT_NONE,      cond: COND_NEVER,      target: S_FETCH};
         S_RD_Q2:     w = '{act: ACT_RD_Q2,     cond: COND_NEVER,      target: S_FETCH};
         S_CAP_Q2:    w = '{act: ACT_CAP_Q2,    cond: COND_NEVER,      target: S_FETCH};
         S_WAIT:      w = '{act: ACT_NONE,      cond: COND_OUT_BUSY,   target: S_WAIT};
         S_EMIT:      w = '{act: ACT_EMIT,      cond: COND_IS_END,     target: S_CLEAR};
         S_PAIR_DONE: w = '{act: ACT_PAIR_DONE, cond: COND_ALWAYS,     target: S_FETCH};
         S_HOLD:      w = '{act: ACT_HOLD,      cond: COND_ALWAYS,     target: S_FETCH};
         S_END:       w = '{act: ACT_NONE,      cond: COND_NO_HELD,    target: S_CLEAR};
         S_PAD:       w = '{act: ACT_SET_PAD,   cond: COND_ALWAYS,     target: S_ENC};
         S_CLEAR:     w = '{act: ACT_CLEAR,     cond: COND_ALWAYS,     target: S_FETCH};
         default:     w = '{act: ACT_NONE,      cond: COND_ALWAYS,     target: S_FETCH};
      endcase
      return w;
   endfunction

   function automatic logic [2:0] row_of(input logic [4:0] p);
      return 3'(p >= 5'd5) + 3'(p >= 5'd10) + 3'(p >= 5'd15) + 3'(p >= 5'd20);
   endfunction

   function automatic logic [2:0] col_of(input logic [4:0] p);
      logic [2:0] r;
      logic [4:0] base;
      r    = row_of(p);
      base = {r[2:0], 2'b00} + 5'(r);
      return 3'(p - base);
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] x);
      return (x == 3'd4) ? 3'd0 : x + 3'd1;
   endfunction

   function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
      return {r, 2'b00} + 5'(r) + 5'(c);
   endfunction

endpackage

// File: hdl/pfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/playfair_digraph_encryptor_unit.sv
// Top level: microcoded Playfair digraph encryptor.
//
// Input words (req_valid/req_ready) carry req_type and req_letter:
// key letter, message letter or end of message. Result words
// (rsp_valid/rsp_ready) carry one encrypted pair each.
// One word is processed at a time; req_ready is high only while the
// sequencer sits in its fetch step. The microcode program walks one
// step per cycle unless it waits for an input word or for the output
// register to drain. The paths through it differ by input word: key
// letter or ignored word, message letter held as first of a pair,
// message letter completing a pair, and end of message, which may pad
// a held letter into a pair; the first message letter also closes the
// key with the 26-letter walk.
// Each pair reads the position RAM twice and the square RAM twice over
// its single read ports. A result sits in an output register; if the
// receiver stalls, the program waits before emitting the next pair.
// Reset empties the square and pairing state (J counts as used); the
// square and position RAMs are left as they are and rewritten on use.
module playfair_digraph_encryptor_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [4:0] req_letter,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_first_cipher,
   output logic [4:0] rsp_second_cipher
);

   pfe_pkg::uword_type uw;

   logic [4:0]  pc_ff, pc_in;
   logic [1:0]  type_ff, type_in;
   logic [4:0]  letter_ff, letter_in;
   logic [4:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic [4:0]  b_ff, b_in;
   logic        split_ff, split_in;
   logic [4:0]  fill_ff, fill_in;
   logic        closed_ff, closed_in;
   logic [25:0] used_ff, used_in;
   logic [4:0]  walk_ff, walk_in;
   logic [4:0]  p1_ff, p1_in;
   logic [4:0]  p2_ff, p2_in;
   logic [4:0]  c1_ff, c1_in;
   logic [4:0]  c2_ff, c2_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_first_ff, rsp_first_in;
   logic [4:0]  rsp_second_ff, rsp_second_in;

   logic       accept;
   logic       cond_true;
   logic       letter_ok;
   logic       place;
   logic [4:0] place_ltr;
   logic [4:0] pos_rd_addr, pos_rd_data;
   logic [4:0] sq_rd_addr, sq_rd_data;
   logic [2:0] r1, c1, r2, c2;
   logic [4:0] q1, q2;

   assign uw        = pfe_pkg::ucode(pc_ff);
   assign req_ready = (pc_ff == pfe_pkg::S_FETCH);
   assign accept    = req_valid && req_ready;
   assign letter_ok = (letter_ff <= pfe_pkg::LETTER_LAST);

   // jump condition
   always_comb begin
      unique case (uw.cond)
         pfe_pkg::COND_NEVER:      cond_true = 1'b0;
         pfe_pkg::COND_ALWAYS:     cond_true = 1'b1;
         pfe_pkg::COND_NO_WORD:    cond_true = !accept;
         pfe_pkg::COND_IS_KEY:     cond_true = (type_ff == pfe_pkg::REQ_KEY);
         pfe_pkg::COND_IS_MSG:     cond_true = (type_ff == pfe_pkg::REQ_MSG);
         pfe_pkg::COND_IS_END:     cond_true = (type_ff == pfe_pkg::REQ_END);
         pfe_pkg::COND_BAD_LETTER: cond_true = !letter_ok;
         pfe_pkg::COND_CLOSED:     cond_true = closed_ff;
         pfe_pkg::COND_WALK_MORE:  cond_true = (walk_ff != pfe_pkg::LETTER_LAST);
         pfe_pkg::COND_IS_J:       cond_true = (letter_ff == pfe_pkg::LETTER_J);
         pfe_pkg::COND_NO_HELD:    cond_true = !held_valid_ff;
         pfe_pkg::COND_OUT_BUSY:   cond_true = rsp_valid_ff;
         default:                  cond_true = 1'b0;
      endcase
   end

   assign pc_in = cond_true ? uw.target : pc_ff + 5'd1;

   // square placement
   always_comb begin
      place_ltr = (uw.act == pfe_pkg::ACT_WALK) ? walk_ff : letter_ff;
      place     = 1'b0;
      if (fill_ff < 5'(pfe_pkg::CELLS)) begin
         if (uw.act == pfe_pkg::ACT_WALK) begin
            place = !used_ff[walk_ff];
         end else if (uw.act == pfe_pkg::ACT_PLACE_IN) begin
            place = !closed_ff && letter_ok && !used_ff[letter_ff];
         end
      end
   end

   // cipher cell selection
   always_comb begin
      r1 = pfe_pkg::row_of(p1_ff);
      c1 = pfe_pkg::col_of(p1_ff);
      r2 = pfe_pkg::row_of(p2_ff);
      c2 = pfe_pkg::col_of(p2_ff);
      priority if (r1 == r2) begin
         q1 = pfe_pkg::cell_at(r1, pfe_pkg::wrap_inc(c1));
         q2 = pfe_pkg::cell_at(r2, pfe_pkg::wrap_inc(c2));
      end else if (c1 == c2) begin
         q1 = pfe_pkg::cell_at(pfe_pkg::wrap_inc(r1), c1);
         q2 = pfe_pkg::cell_at(pfe_pkg::wrap_inc(r2), c2);
      end else begin
         q1 = pfe_pkg::cell_at(r1, c2);
         q2 = pfe_pkg::cell_at(r2, c1);
      end
   end

   assign pos_rd_addr = (uw.act == pfe_pkg::ACT_RD_PB) ? b_ff : held_ff;
   assign sq_rd_addr  = (uw.act == pfe_pkg::ACT_RD_Q2) ? q2 : q1;

   pfe_ram #(
      .WIDTH (pfe_pkg::LETTER_W),
      .DEPTH (pfe_pkg::CELLS)
   ) u_square (
      .clock   (clock),
      .wr_en   (place),
      .wr_addr (fill_ff),
      .wr_data (place_ltr),
      .rd_addr (sq_rd_addr),
      .rd_data (sq_rd_data)
   );

   pfe_ram #(
      .WIDTH (pfe_pkg::LETTER_W),
      .DEPTH (pfe_pkg::LETTERS)
   ) u_position (
      .clock   (clock),
      .wr_en   (place),
      .wr_addr (place_ltr),
      .wr_data (fill_ff),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd_data)
   );

   // datapath actions
   always_comb begin
      type_in       = type_ff;
      letter_in     = letter_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      b_in          = b_ff;
      split_in      = split_ff;
      fill_in       = fill_ff;
      closed_in     = closed_ff;
      used_in       = used_ff;
      walk_in       = walk_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;

      if (accept) begin
         type_in   = req_type;
         letter_in = req_letter;
      end
      if (place) begin
         used_in[place_ltr] = 1'b1;
         fill_in            = fill_ff + 5'd1;
      end

      unique case (uw.act)
         pfe_pkg::ACT_NONE,
         pfe_pkg::ACT_PLACE_IN,
         pfe_pkg::ACT_RD_Q2: begin
         end
         pfe_pkg::ACT_WALK_CLR: begin
            walk_in = '0;
         end
         pfe_pkg::ACT_WALK: begin
            walk_in = walk_ff + 5'd1;
         end
         pfe_pkg::ACT_CLOSE: begin
            closed_in = 1'b1;
         end
         pfe_pkg::ACT_SET_B: begin
            split_in = (letter_ff == held_ff);
            if (letter_ff == held_ff) begin
               b_in = (held_ff == pfe_pkg::LETTER_X) ? pfe_pkg::LETTER_Q : pfe_pkg::LETTER_X;
            end else begin
               b_in = letter_ff;
            end
         end
         pfe_pkg::ACT_RD_PB: begin
            p1_in = pos_rd_data;
         end
         pfe_pkg::ACT_CAP_PB: begin
            p2_in = pos_rd_data;
         end
         pfe_pkg::ACT_CAP_Q2: begin
            c2_in = sq_rd_data;
         end
         pfe_pkg::ACT_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_first_in  = c1_ff;
            rsp_second_in = c2_ff;
         end
         pfe_pkg::ACT_PAIR_DONE: begin
            if (!split_ff) begin
               held_valid_in = 1'b0;
            end
         end
         pfe_pkg::ACT_HOLD: begin
            held_in       = letter_ff;
            held_valid_in = 1'b1;
         end
         pfe_pkg::ACT_SET_PAD: begin
            b_in     = pfe_pkg::LETTER_X;
            split_in = 1'b0;
         end
         pfe_pkg::ACT_CLEAR: begin
            used_in                   = '0;
            used_in[pfe_pkg::LETTER_J] = 1'b1;
            fill_in                   = '0;
            closed_in                 = 1'b0;
            held_in                   = '0;
            held_valid_in             = 1'b0;
         end
         default: begin
         end
      endcase

      // c1 captures the q1 read data in the cycle the q2 read is issued
      if (uw.act == pfe_pkg::ACT_RD_Q2) begin
         c1_in = sq_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= pfe_pkg::S_FETCH;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         fill_ff       <= '0;
         closed_ff     <= 1'b0;
         used_ff       <= 26'(1) << pfe_pkg::LETTER_J;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         fill_ff       <= fill_in;
         closed_ff     <= closed_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      type_ff       <= type_in;
      letter_ff     <= letter_in;
      b_ff          <= b_in;
      split_ff      <= split_in;
      walk_ff       <= walk_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_cipher  = rsp_first_ff;
   assign rsp_second_cipher = rsp_second_ff;

endmodule

// File: hdl/pfe_checker.sv
// Port-level checker for the Playfair encryptor, bound to the top level.
`include "playfair_digraph_encryptor_unit_defines.svh"

module pfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic [4:0] req_letter,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_first_cipher,
   input logic [4:0] rsp_second_cipher
);

   `PFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_first_cipher) && $stable(rsp_second_cipher), "stalled result word changed")

   `PFE_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready, "input word taken while busy")

   `PFE_ASSERT_NOW(a_emit_busy, clock, reset, $rose(rsp_valid), !req_ready, "result emitted from fetch step")

   `PFE_ASSERT_NOW(a_letters, clock, reset, rsp_valid, (rsp_first_cipher <= 5'd25) && (rsp_second_cipher <= 5'd25), "cipher letter out of range")

endmodule

bind playfair_digraph_encryptor_unit pfe_checker u_pfe_checker (.*);
